[hw/rtl/hxtp_pkg.sv]
// Shared types, codes and helpers for the hex exchange trace parser.
`timescale 1ns / 1ps

package hxtp_pkg;

    // Width of the completed line counter.
    localparam int LINE_COUNT_BITS = 16;

    // Result kinds
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_EXCH   = 2'd1;
    localparam logic [1:0] KIND_ACCEPT = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_BAD_DIR       = 3'd0;
    localparam logic [2:0] ERR_TWO_REQ       = 3'd1;
    localparam logic [2:0] ERR_ORPHAN_RSP    = 3'd2;
    localparam logic [2:0] ERR_BAD_TOKEN     = 3'd3;
    localparam logic [2:0] ERR_EMPTY_REQ     = 3'd4;
    localparam logic [2:0] ERR_EMPTY_RSP     = 3'd5;
    localparam logic [2:0] ERR_UNMATCHED_REQ = 3'd6;
    localparam logic [2:0] ERR_NO_EXCH       = 3'd7;

    // Characters
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_HASH    = 8'h23;
    localparam logic [7:0] CH_REQ     = 8'h3E;
    localparam logic [7:0] CH_RSP     = 8'h3C;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_LOW_X   = 8'h78;
    localparam logic [7:0] CH_UP_X    = 8'h58;

    typedef struct packed {
        logic [1:0]  kind;
        logic        is_response;
        logic [7:0]  byte_value;
        logic [2:0]  error_code;
        logic [15:0] line_number;
    } t_result;

    typedef struct packed {
        logic [1:0]        count;
        t_result [2:0]     item;
    } t_bundle;

    function automatic t_result mk_result(input logic [1:0] kind, input logic resp,
                                          input logic [7:0] value, input logic [2:0] code,
                                          input logic [15:0] line);
        t_result r;
        r.kind        = kind;
        r.is_response = resp;
        r.byte_value  = value;
        r.error_code  = code;
        r.line_number = line;
        return r;
    endfunction

    // Clamp a line count to the 16-bit reporting range.
    function automatic logic [15:0] sat_line(input logic [LINE_COUNT_BITS-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
    endfunction

    function automatic logic is_ws(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

endpackage

[hw/rtl/hxtp_core.sv]
// Parser state and per-character step logic producing a bundle of results.
`timescale 1ns / 1ps

module hxtp_core
    import hxtp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  logic [7:0]    i_char,
    input  logic          i_eos,
    output t_bundle       o_bundle
);

    localparam logic [1:0] PH_LEAD    = 2'd0;
    localparam logic [1:0] PH_BETWEEN = 2'd1;
    localparam logic [1:0] PH_TOKEN   = 2'd2;
    localparam logic [1:0] PH_COMMENT = 2'd3;

    localparam logic [LINE_COUNT_BITS-1:0] COUNT_MAX = {LINE_COUNT_BITS{1'b1}};

    logic [1:0]                 r_phase, n_phase;
    logic                       r_expect_req, n_expect_req;
    logic                       r_line_rsp, n_line_rsp;
    logic [2:0]                 r_tok_len, n_tok_len;
    logic                       r_tok_prefix, n_tok_prefix;
    logic                       r_tok_hex, n_tok_hex;
    logic [7:0]                 r_nibbles, n_nibbles;
    logic                       r_has_byte, n_has_byte;
    logic                       r_any_exch, n_any_exch;
    logic [LINE_COUNT_BITS-1:0] r_lines, n_lines;
    logic                       r_stopped, n_stopped;
    logic                       r_dir_seen, n_dir_seen;
    logic                       r_line_open, n_line_open;

    logic [15:0]                cur_line;
    logic [15:0]                eos_line;
    logic                       tok_ok;
    logic                       c_ws;
    logic [3:0]                 hex_val;
    logic                       c_hex;

    always_comb begin
        cur_line = sat_line((r_lines != COUNT_MAX) ? r_lines + LINE_COUNT_BITS'(1) : r_lines);
        eos_line = sat_line((r_line_open && (r_lines != COUNT_MAX)) ?
                            r_lines + LINE_COUNT_BITS'(1) : r_lines);
        tok_ok   = ((r_tok_len == 3'd2) && r_tok_hex) ||
                   ((r_tok_len == 3'd4) && r_tok_prefix && r_tok_hex);
        c_ws     = is_ws(i_char);
        c_hex    = 1'b1;
        hex_val  = 4'd0;
        if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            hex_val = 4'(i_char - 8'h30);
        end else if ((i_char >= 8'h61) && (i_char <= 8'h66)) begin
            hex_val = 4'(i_char - 8'h57);
        end else if ((i_char >= 8'h41) && (i_char <= 8'h46)) begin
            hex_val = 4'(i_char - 8'h37);
        end else begin
            c_hex = 1'b0;
        end
    end

    always_comb begin
        logic ok;
        logic [1:0] cnt;
        n_phase      = r_phase;
        n_expect_req = r_expect_req;
        n_line_rsp   = r_line_rsp;
        n_tok_len    = r_tok_len;
        n_tok_prefix = r_tok_prefix;
        n_tok_hex    = r_tok_hex;
        n_nibbles    = r_nibbles;
        n_has_byte   = r_has_byte;
        n_any_exch   = r_any_exch;
        n_lines      = r_lines;
        n_stopped    = r_stopped;
        n_dir_seen   = r_dir_seen;
        n_line_open  = r_line_open;
        o_bundle     = '0;
        ok           = 1'b1;
        cnt          = 2'd0;

        if (i_fire && !r_stopped) begin
            if (i_eos || (i_char == CH_NEWLINE)) begin
                // Close the line: judge an open token, then the line itself.
                if (r_phase == PH_TOKEN) begin
                    if (!tok_ok) begin
                        o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                                                       ERR_BAD_TOKEN, cur_line);
                        cnt = cnt + 2'd1;
                        ok  = 1'b0;
                    end else begin
                        o_bundle.item[cnt] = mk_result(KIND_DATA, r_line_rsp, r_nibbles,
                                                       ERR_BAD_DIR, cur_line);
                        cnt = cnt + 2'd1;
                    end
                end
                if (ok && r_dir_seen) begin
                    if (!(r_has_byte || (r_phase == PH_TOKEN))) begin
                        o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                            r_line_rsp ? ERR_EMPTY_RSP : ERR_EMPTY_REQ, cur_line);
                        cnt = cnt + 2'd1;
                        ok  = 1'b0;
                    end else if (r_line_rsp) begin
                        o_bundle.item[cnt] = mk_result(KIND_EXCH, 1'b0, 8'd0,
                                                       ERR_BAD_DIR, cur_line);
                        cnt          = cnt + 2'd1;
                        n_any_exch   = 1'b1;
                        n_expect_req = 1'b1;
                    end else begin
                        n_expect_req = 1'b0;
                    end
                end
                if (i_eos) begin
                    if (ok) begin
                        if (!n_expect_req) begin
                            o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                                                           ERR_UNMATCHED_REQ, eos_line);
                        end else if (!n_any_exch) begin
                            o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                                                           ERR_NO_EXCH, eos_line);
                        end else begin
                            o_bundle.item[cnt] = mk_result(KIND_ACCEPT, 1'b0, 8'd0,
                                                           ERR_BAD_DIR, eos_line);
                        end
                        cnt = cnt + 2'd1;
                    end
                    n_stopped = 1'b1;
                end else if (!ok) begin
                    n_stopped = 1'b1;
                end else begin
                    if (r_lines != COUNT_MAX) begin
                        n_lines = r_lines + LINE_COUNT_BITS'(1);
                    end
                    n_phase      = PH_LEAD;
                    n_line_rsp   = 1'b0;
                    n_has_byte   = 1'b0;
                    n_dir_seen   = 1'b0;
                    n_line_open  = 1'b0;
                    n_tok_len    = 3'd0;
                    n_tok_prefix = 1'b0;
                    n_tok_hex    = 1'b1;
                    n_nibbles    = 8'd0;
                end
            end else begin
                n_line_open = 1'b1;
                if (r_phase == PH_COMMENT) begin
                    // drop everything up to the newline
                end else if ((r_phase == PH_TOKEN) && ((i_char == CH_HASH) || c_ws)) begin
                    // Token ends: emit its byte or stop on a malformed one.
                    if (!tok_ok) begin
                        o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                                                       ERR_BAD_TOKEN, cur_line);
                        cnt       = cnt + 2'd1;
                        n_stopped = 1'b1;
                    end else begin
                        o_bundle.item[cnt] = mk_result(KIND_DATA, r_line_rsp, r_nibbles,
                                                       ERR_BAD_DIR, cur_line);
                        cnt          = cnt + 2'd1;
                        n_has_byte   = 1'b1;
                        n_tok_len    = 3'd0;
                        n_tok_prefix = 1'b0;
                        n_tok_hex    = 1'b1;
                        n_nibbles    = 8'd0;
                        n_phase      = (i_char == CH_HASH) ? PH_COMMENT : PH_BETWEEN;
                    end
                end else if (i_char == CH_HASH) begin
                    n_phase = PH_COMMENT;
                end else if (r_phase == PH_LEAD) begin
                    if (!c_ws) begin
                        if ((i_char == CH_REQ) && r_expect_req) begin
                            n_dir_seen = 1'b1;
                            n_line_rsp = 1'b0;
                            n_phase    = PH_BETWEEN;
                        end else if ((i_char == CH_RSP) && !r_expect_req) begin
                            n_dir_seen = 1'b1;
                            n_line_rsp = 1'b1;
                            n_phase    = PH_BETWEEN;
                        end else begin
                            o_bundle.item[cnt] = mk_result(KIND_ERROR, 1'b0, 8'd0,
                                (i_char == CH_REQ) ? ERR_TWO_REQ :
                                (i_char == CH_RSP) ? ERR_ORPHAN_RSP : ERR_BAD_DIR,
                                cur_line);
                            cnt       = cnt + 2'd1;
                            n_stopped = 1'b1;
                        end
                    end
                end else if (!((r_phase == PH_BETWEEN) && c_ws)) begin
                    // Collect one token character.
                    n_phase   = PH_TOKEN;
                    n_nibbles = {r_nibbles[3:0], hex_val};
                    case (r_tok_len)
                        3'd0: begin
                            n_tok_hex    = c_hex;
                            n_tok_prefix = (i_char == CH_ZERO);
                        end
                        3'd1: begin
                            n_tok_prefix = r_tok_prefix &&
                                           ((i_char == CH_LOW_X) || (i_char == CH_UP_X));
                            n_tok_hex    = r_tok_hex && c_hex;
                        end
                        3'd2: n_tok_hex = c_hex;
                        3'd3: n_tok_hex = r_tok_hex && c_hex;
                        default: ;
                    endcase
                    if (r_tok_len < 3'd5) begin
                        n_tok_len = r_tok_len + 3'd1;
                    end
                end
            end
        end
        o_bundle.count = cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_LEAD;
            r_expect_req <= 1'b1;
            r_line_rsp   <= 1'b0;
            r_tok_len    <= 3'd0;
            r_tok_prefix <= 1'b0;
            r_tok_hex    <= 1'b1;
            r_nibbles    <= 8'd0;
            r_has_byte   <= 1'b0;
            r_any_exch   <= 1'b0;
            r_lines      <= '0;
            r_stopped    <= 1'b0;
            r_dir_seen   <= 1'b0;
            r_line_open  <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_expect_req <= n_expect_req;
            r_line_rsp   <= n_line_rsp;
            r_tok_len    <= n_tok_len;
            r_tok_prefix <= n_tok_prefix;
            r_tok_hex    <= n_tok_hex;
            r_nibbles    <= n_nibbles;
            r_has_byte   <= n_has_byte;
            r_any_exch   <= n_any_exch;
            r_lines      <= n_lines;
            r_stopped    <= n_stopped;
            r_dir_seen   <= n_dir_seen;
            r_line_open  <= n_line_open;
        end
    end

endmodule

[hw/rtl/hxtp_outq.sv]
// Result register holding up to three results and draining them in order.
`timescale 1ns / 1ps

module hxtp_outq
    import hxtp_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_load,
    input  t_bundle       i_bundle,
    output logic          o_free,
    output logic          o_valid,
    input  logic          i_stall,
    output t_result       o_head,
    output logic          o_last
);

    logic [1:0]    r_cnt, n_cnt;
    t_result [2:0] r_item, n_item;
    logic          xfer;

    assign xfer    = (r_cnt != 2'd0) && !i_stall;
    assign o_free  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && !i_stall);
    assign o_valid = (r_cnt != 2'd0);
    assign o_head  = r_item[0];
    assign o_last  = (r_cnt == 2'd1);

    always_comb begin
        n_cnt  = r_cnt;
        n_item = r_item;
        if (i_load) begin
            n_cnt  = i_bundle.count;
            n_item = i_bundle.item;
        end else if (xfer) begin
            // advance the queue by one transfer
            n_cnt     = r_cnt - 2'd1;
            n_item[0] = r_item[1];
            n_item[1] = r_item[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item <= n_item;
    end

endmodule

[hw/rtl/hex_exchange_trace_parser.sv]
// Top level of the hex exchange trace parser: input register, parser core, result queue.
`timescale 1ns / 1ps

//  channel   direction  handshake            payload
//  -------   ---------  -------------------  ------------------------------------------
//  input     in         i_valid / o_stall    i_char_in, i_end_of_stream
//  result    out        o_valid / i_stall    o_kind, o_is_response, o_byte_value,
//                                            o_error_code, o_line_number, o_last
//
//  One character is taken per cycle while o_stall is low; it steps the parser from the
//  input register once the result queue is free. One that yields k results (at most
//  three) holds the input side for the single-result-per-cycle drain of the result
//  queue, halted by i_stall. Results leave from that queue, behind the input register.
//  Reset is synchronous and active low; it clears the parser state and empties
//  both the input register and the result queue.
//  A stall on the result side backs up into o_stall once the queue cannot take the
//  next bundle. After an error or the end-of-stream verdict the block drops every
//  further character until reset.

module hex_exchange_trace_parser
    import hxtp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_char_in,
    input  logic        i_end_of_stream,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic        o_is_response,
    output logic [7:0]  o_byte_value,
    output logic [2:0]  o_error_code,
    output logic [15:0] o_line_number,
    output logic        o_last
);

    // Input register
    logic       r_in_valid, n_in_valid;
    logic [7:0] r_char;
    logic       r_eos;

    logic       in_xfer;
    logic       fire;
    logic       q_free;
    t_bundle    bundle;
    t_result    head;

    // Step the parser when the queue can take whatever this character produces.
    assign fire       = r_in_valid && q_free;
    assign o_stall    = r_in_valid && !q_free;
    assign in_xfer    = i_valid && !o_stall;
    assign n_in_valid = in_xfer || (r_in_valid && !fire);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    // hold the payload until the parser consumes it
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_char <= i_char_in;
            r_eos  <= i_end_of_stream;
        end
    end

    hxtp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_char   (r_char),
        .i_eos    (r_eos),
        .o_bundle (bundle)
    );

    hxtp_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && (bundle.count != 2'd0)),
        .i_bundle (bundle),
        .o_free   (q_free),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_head   (head),
        .o_last   (o_last)
    );

    assign o_kind        = head.kind;
    assign o_is_response = head.is_response;
    assign o_byte_value  = head.byte_value;
    assign o_error_code  = head.error_code;
    assign o_line_number = head.line_number;

endmodule

[dv/tb_hex_exchange_trace_parser.sv]
// Self-checking testbench for the hex exchange trace parser.
`timescale 1ns / 1ps

module tb_hex_exchange_trace_parser;
    import hxtp_pkg::*;

    // Characters not named in the package
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_VT       = 8'h0B;
    localparam logic [7:0] CH_FORMFEED = 8'h0C;
    localparam logic [7:0] CH_CR       = 8'h0D;

    // Error code field value carried by every non-error result
    localparam logic [2:0] NO_CODE = 3'd0;
    localparam t_result NO_EVENT = '0;
    localparam logic [LINE_COUNT_BITS-1:0] LINE_MAX = '1;

    // Minimum number of characters in the random well-formed part
    localparam int RANDOM_CHARS = 290;

    typedef enum logic [1:0] {PH_LEAD, PH_GAP, PH_TOKEN, PH_COMMENT} t_parse_phase;

    // How the trace ends; each one but the first breaks the trace on purpose
    typedef enum logic [2:0] {
        END_ACCEPT, END_OPEN_REQ, END_BAD_DIR, END_TWO_REQ,
        END_ORPHAN, END_BAD_TOKEN, END_EMPTY_REQ, END_EMPTY_RSP
    } t_trace_ending;

    typedef struct packed {
        t_result res;
        logic    last;
    } t_trace_event;

    typedef struct packed {
        logic [7:0] ch;
        logic       typed;
        t_result    want;
    } t_script_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_char_in;
    logic        i_end_of_stream;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_kind;
    logic        o_is_response;
    logic [7:0]  o_byte_value;
    logic [2:0]  o_error_code;
    logic [15:0] o_line_number;
    logic        o_last;

    hex_exchange_trace_parser i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_char_in       (i_char_in),
        .i_end_of_stream (i_end_of_stream),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_kind          (o_kind),
        .o_is_response   (o_is_response),
        .o_byte_value    (o_byte_value),
        .o_error_code    (o_error_code),
        .o_line_number   (o_line_number),
        .o_last          (o_last)
    );

    // ------------------------------------------------------------------
    // Parser mirror: state of the trace as the block should see it
    // ------------------------------------------------------------------
    t_parse_phase                ph          = PH_LEAD;
    logic                        want_req    = 1'b1;
    logic                        on_rsp_line = 1'b0;
    logic                        dir_seen    = 1'b0;
    logic                        line_open   = 1'b0;
    logic                        has_byte    = 1'b0;
    logic                        any_exch    = 1'b0;
    logic                        halted      = 1'b0;
    logic [2:0]                  tok_len     = '0;
    logic                        tok_prefix  = 1'b0;
    logic                        tok_hex     = 1'b1;
    logic [7:0]                  tok_val     = '0;
    logic [LINE_COUNT_BITS-1:0]  lines_done  = '0;

    t_trace_event step_out[$];   // results of the character just taken
    t_trace_event pending[$];    // results still owed by the block

    int errors      = 0;
    int chars_sent  = 0;
    int idle_pct    = 30;
    int rx_pct      = 30;
    logic quiet     = 1'b0;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [15:0] clamp_line(input logic [LINE_COUNT_BITS-1:0] v);
        return (32'(v) > 32'h0000_FFFF) ? 16'hFFFF : 16'(v);
    endfunction

    // One-based number of the line being parsed
    function automatic logic [15:0] line_now();
        logic [LINE_COUNT_BITS-1:0] v;
        v = lines_done;
        if (v != LINE_MAX) v = v + LINE_COUNT_BITS'(1);
        return clamp_line(v);
    endfunction

    function automatic void note(input logic [1:0] kind, input logic resp,
                                 input logic [7:0] value, input logic [2:0] code,
                                 input logic [15:0] line);
        t_trace_event ev;
        ev.res.kind        = kind;
        ev.res.is_response = resp;
        ev.res.byte_value  = value;
        ev.res.error_code  = code;
        ev.res.line_number = line;
        ev.last            = 1'b0;
        step_out = {step_out, ev};
    endfunction

    // Report an error and freeze the parser until reset
    function automatic void raise_error(input logic [2:0] code, input logic [15:0] line);
        note(KIND_ERROR, 1'b0, 8'h00, code, line);
        halted = 1'b1;
    endfunction

    function automatic void tok_clear();
        tok_len    = '0;
        tok_prefix = 1'b0;
        tok_hex    = 1'b1;
        tok_val    = '0;
    endfunction

    function automatic void line_clear();
        ph          = PH_LEAD;
        on_rsp_line = 1'b0;
        has_byte    = 1'b0;
        dir_seen    = 1'b0;
        line_open   = 1'b0;
        tok_clear();
    endfunction

    function automatic void tok_feed(input logic [7:0] c);
        logic [3:0] nib;
        logic       hexy;
        hexy = 1'b1;
        nib  = '0;
        if (c >= "0" && c <= "9") nib = 4'(c - "0");
        else if (c >= "a" && c <= "f") nib = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") nib = 4'(c - "A" + 8'd10);
        else hexy = 1'b0;
        tok_val = {tok_val[3:0], nib};
        case (tok_len)
            3'd0: begin
                tok_hex    = hexy;
                tok_prefix = (c == CH_ZERO);
            end
            3'd1: begin
                tok_prefix = tok_prefix && ((c == CH_LOW_X) || (c == CH_UP_X));
                tok_hex    = tok_hex && hexy;
            end
            3'd2: tok_hex = hexy;
            3'd3: tok_hex = tok_hex && hexy;
            default: ;
        endcase
        if (tok_len < 3'd5) tok_len = tok_len + 3'd1;
    endfunction

    // Judge the token that just ended; emit its byte when it is well formed
    function automatic logic tok_close();
        logic ok;
        ok = ((tok_len == 3'd2) && tok_hex) || ((tok_len == 3'd4) && tok_prefix && tok_hex);
        if (!ok) begin
            raise_error(ERR_BAD_TOKEN, line_now());
            return 1'b0;
        end
        note(KIND_DATA, on_rsp_line, tok_val, NO_CODE, line_now());
        has_byte = 1'b1;
        tok_clear();
        return 1'b1;
    endfunction

    function automatic logic line_close();
        if (ph == PH_TOKEN && !tok_close()) return 1'b0;
        if (dir_seen) begin
            if (!has_byte) begin
                raise_error(on_rsp_line ? ERR_EMPTY_RSP : ERR_EMPTY_REQ, line_now());
                return 1'b0;
            end
            if (on_rsp_line) begin
                note(KIND_EXCH, 1'b0, 8'h00, NO_CODE, line_now());
                any_exch = 1'b1;
                want_req = 1'b1;
            end else begin
                want_req = 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Advance the mirror by one transfer and collect the results it causes
    function automatic void parse_step(input logic [7:0] c, input logic eos);
        logic [LINE_COUNT_BITS-1:0] cnt;
        logic [15:0]                verdict_line;
        step_out.delete();
        if (halted) return;
        if (eos) begin
            if (line_close()) begin
                // an unterminated last line counts once it holds anything
                cnt = lines_done;
                if (line_open && cnt != LINE_MAX) cnt = cnt + LINE_COUNT_BITS'(1);
                verdict_line = clamp_line(cnt);
                if (!want_req) raise_error(ERR_UNMATCHED_REQ, verdict_line);
                else if (!any_exch) raise_error(ERR_NO_EXCH, verdict_line);
                else note(KIND_ACCEPT, 1'b0, 8'h00, NO_CODE, verdict_line);
            end
            halted = 1'b1;
        end else if (c == CH_NEWLINE) begin
            if (line_close()) begin
                if (lines_done != LINE_MAX) lines_done = lines_done + LINE_COUNT_BITS'(1);
                line_clear();
            end
        end else begin
            line_open = 1'b1;
            if (ph == PH_COMMENT) begin
                // swallow everything up to the newline
            end else if (c == CH_HASH) begin
                if (ph != PH_TOKEN || tok_close()) ph = PH_COMMENT;
            end else if (ph == PH_LEAD) begin
                if (!is_blank(c)) begin
                    if (c == CH_REQ) begin
                        if (!want_req) raise_error(ERR_TWO_REQ, line_now());
                        else begin
                            dir_seen    = 1'b1;
                            on_rsp_line = 1'b0;
                            ph          = PH_GAP;
                        end
                    end else if (c == CH_RSP) begin
                        if (want_req) raise_error(ERR_ORPHAN_RSP, line_now());
                        else begin
                            dir_seen    = 1'b1;
                            on_rsp_line = 1'b1;
                            ph          = PH_GAP;
                        end
                    end else begin
                        raise_error(ERR_BAD_DIR, line_now());
                    end
                end
            end else if (ph == PH_GAP) begin
                if (!is_blank(c)) begin
                    ph = PH_TOKEN;
                    tok_feed(c);
                end
            end else begin
                if (is_blank(c)) begin
                    if (tok_close()) ph = PH_GAP;
                end else begin
                    tok_feed(c);
                end
            end
        end
        if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Clock and timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cap the run well beyond the slowest legal schedule
    initial begin
        #5_000_000;
        $display("tb_hex_exchange_trace_parser: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Sender: one character per transfer
    // ------------------------------------------------------------------
    task automatic push_char(input logic [7:0] ch, input logic eos,
                             input logic typed, input t_result want);
        t_trace_event ev;
        // drop valid for a random burst now and then
        if (!quiet && $urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_valid         <= 1'b1;
        i_char_in       <= ch;
        i_end_of_stream <= eos;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        // the transfer happened at this edge
        chars_sent++;
        parse_step(ch, eos);
        if (typed) begin
            ev.res  = want;
            ev.last = 1'b1;
            pending = {pending, ev};
        end else begin
            foreach (step_out[k]) pending = {pending, step_out[k]};
        end
    endtask

    task automatic feed(input logic [7:0] ch);
        push_char(ch, 1'b0, 1'b0, NO_EVENT);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_VT;
            3: return CH_FORMFEED;
            default: return CH_CR;
        endcase
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        if (nib < 4'd10) return CH_ZERO + 8'(nib);
        return ($urandom_range(0, 1) ? "A" : "a") + 8'(nib - 4'd10);
    endfunction

    task automatic feed_blanks();
        repeat ($urandom_range(1, 2)) feed(pick_blank());
    endtask

    // Two hex digits, bare or behind a 0x / 0X prefix
    task automatic feed_token();
        logic [7:0] b;
        int         form;
        b    = 8'($urandom_range(0, 255));
        form = $urandom_range(0, 2);
        if (form != 0) begin
            feed(CH_ZERO);
            feed(form == 1 ? CH_LOW_X : CH_UP_X);
        end
        feed(hex_char(b[7:4]));
        feed(hex_char(b[3:0]));
    endtask

    // Comment body takes any byte but the newline, so char bit 7 toggles here
    task automatic feed_comment();
        logic [7:0] c;
        feed(CH_HASH);
        repeat ($urandom_range(0, 6)) begin
            c = 8'($urandom_range(0, 255));
            feed(c == CH_NEWLINE ? CH_HASH : c);
        end
    endtask

    task automatic feed_dir_line(input logic rsp);
        int n;
        if ($urandom_range(0, 1)) feed_blanks();
        feed(rsp ? CH_RSP : CH_REQ);
        if ($urandom_range(0, 1)) feed_blanks();
        n = $urandom_range(1, 4);
        for (int t = 0; t < n; t++) begin
            if (t > 0) feed_blanks();
            feed_token();
        end
        if ($urandom_range(0, 1)) feed_blanks();
        if ($urandom_range(0, 3) == 0) feed_comment();
        feed(CH_NEWLINE);
    endtask

    // Lines the parser must skip: empty, blank only, comment only
    task automatic feed_noise_line();
        case ($urandom_range(0, 2))
            0: ;
            1: feed_blanks();
            default: begin
                if ($urandom_range(0, 1)) feed_blanks();
                feed_comment();
            end
        endcase
        feed(CH_NEWLINE);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stall bursts, none once the run goes quiet
    // ------------------------------------------------------------------
    initial begin
        i_stall <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (quiet) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 99) < rx_pct) begin
                i_stall <= 1'b1;
                repeat ($urandom_range(1, 18)) @(posedge i_clk);
            end else begin
                i_stall <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge i_clk);
            end
            if ($urandom_range(0, 15) == 0) begin
                case ($urandom_range(0, 2))
                    0: rx_pct = 0;
                    1: rx_pct = 25;
                    default: rx_pct = 70;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each transfer against the oldest expectation
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_trace_event want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual kind %0h line %0h",
                         $time, o_kind, o_line_number);
                errors++;
            end else begin
                want = pending.pop_front();
                check_field("kind", 16'(want.res.kind), 16'(o_kind));
                check_field("is_response", 16'(want.res.is_response), 16'(o_is_response));
                check_field("byte_value", 16'(want.res.byte_value), 16'(o_byte_value));
                check_field("error_code", 16'(want.res.error_code), 16'(o_error_code));
                check_field("line_number", want.res.line_number, o_line_number);
                check_field("last", 16'(want.last), 16'(o_last));
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    // Directed trace: blank line, comment with extreme bytes, a request with
    // bare and prefixed tokens ended by blank and by '#', then a response
    // with an upper-case prefix that closes the first exchange.
    t_script_row script [23];

    initial begin : stimulus
        t_trace_ending ending;
        logic [7:0]    c;

        script = '{
            '{CH_SPACE,   1'b0, NO_EVENT},
            '{CH_NEWLINE, 1'b0, NO_EVENT},
            '{CH_HASH,    1'b0, NO_EVENT},
            '{8'hFF,      1'b0, NO_EVENT},
            '{8'h00,      1'b0, NO_EVENT},
            '{CH_NEWLINE, 1'b0, NO_EVENT},
            '{CH_TAB,     1'b0, NO_EVENT},
            '{CH_REQ,     1'b0, NO_EVENT},
            '{"f",        1'b0, NO_EVENT},
            '{"F",        1'b0, NO_EVENT},
            '{CH_SPACE,   1'b1, '{KIND_DATA, 1'b0, 8'hFF, NO_CODE, 16'd3}},
            '{CH_ZERO,    1'b0, NO_EVENT},
            '{CH_LOW_X,   1'b0, NO_EVENT},
            '{CH_ZERO,    1'b0, NO_EVENT},
            '{CH_ZERO,    1'b0, NO_EVENT},
            '{CH_HASH,    1'b1, '{KIND_DATA, 1'b0, 8'h00, NO_CODE, 16'd3}},
            '{CH_NEWLINE, 1'b0, NO_EVENT},
            '{CH_RSP,     1'b0, NO_EVENT},
            '{CH_ZERO,    1'b0, NO_EVENT},
            '{CH_UP_X,    1'b0, NO_EVENT},
            '{"a",        1'b0, NO_EVENT},
            '{"9",        1'b0, NO_EVENT},
            '{CH_NEWLINE, 1'b0, NO_EVENT}
        };

        // hold every input at a known value through reset
        i_rst_n         <= 1'b0;
        i_valid         <= 1'b0;
        i_char_in       <= '0;
        i_end_of_stream <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (script[k]) push_char(script[k].ch, 1'b0, script[k].typed, script[k].want);

        // hold the sender until the block has drained completely
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending.size() != 0) @(posedge i_clk);

        // Random part: mostly well-formed exchanges, with skipped lines mixed in
        chars_sent = 0;
        while (chars_sent < RANDOM_CHARS) begin
            if ($urandom_range(0, 9) == 0) begin
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = 20;
                    default: idle_pct = 60;
                endcase
            end
            if ($urandom_range(0, 3) == 0) begin
                feed_noise_line();
            end else begin
                feed_dir_line(1'b0);
                if ($urandom_range(0, 3) == 0) feed_noise_line();
                feed_dir_line(1'b1);
            end
        end

        // Last part: no idling on either side
        quiet = 1'b1;
        feed_dir_line(1'b0);
        feed_dir_line(1'b1);

        // End the trace cleanly or break it in one of the ways the block reports
        ending = t_trace_ending'($urandom_range(0, 7));
        case (ending)
            END_ACCEPT: begin
                // optionally leave a last line open without its newline
                if ($urandom_range(0, 1)) begin
                    feed_blanks();
                    feed_comment();
                end
            end
            END_OPEN_REQ: begin
                feed(CH_REQ);
                feed(CH_SPACE);
                feed_token();
            end
            END_BAD_DIR: begin
                c = 8'($urandom_range(0, 255));
                if (is_blank(c) || c == CH_HASH || c == CH_REQ || c == CH_RSP) c = "?";
                feed(c);
            end
            END_TWO_REQ: begin
                feed_dir_line(1'b0);
                feed(CH_REQ);
            end
            END_ORPHAN: feed(CH_RSP);
            END_BAD_TOKEN: begin
                feed(CH_REQ);
                feed(CH_SPACE);
                case ($urandom_range(0, 3))
                    0: begin
                        feed(hex_char(4'($urandom_range(0, 15))));
                        feed("g");
                    end
                    1: repeat (3) feed(hex_char(4'($urandom_range(0, 15))));
                    2: begin
                        feed(CH_ZERO);
                        feed("y");
                        repeat (2) feed(hex_char(4'($urandom_range(0, 15))));
                    end
                    default: repeat (5) feed(hex_char(4'($urandom_range(0, 15))));
                endcase
                feed(CH_NEWLINE);
            end
            END_EMPTY_REQ: begin
                feed(CH_REQ);
                feed_blanks();
                feed(CH_NEWLINE);
            end
            default: begin
                feed_dir_line(1'b0);
                feed(CH_RSP);
                if ($urandom_range(0, 1)) feed_comment();
                feed(CH_NEWLINE);
            end
        endcase
        push_char(8'($urandom_range(0, 255)), 1'b1, 1'b0, NO_EVENT);

        // the block is stopped now: these must vanish
        repeat (3) feed(8'($urandom_range(0, 255)));
        i_valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb_hex_exchange_trace_parser: PASS");
        end else begin
            $display("tb_hex_exchange_trace_parser: FAIL");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/hxtp_pkg.sv
hw/rtl/hxtp_core.sv
hw/rtl/hxtp_outq.sv
hw/rtl/hex_exchange_trace_parser.sv
dv/tb_hex_exchange_trace_parser.sv
